/* design/small_isa_cpu_step_assert.svh */
// Assertion macros for the small ISA processor step block.
`ifndef SMALL_ISA_CPU_STEP_ASSERT_SVH
`define SMALL_ISA_CPU_STEP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SIC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/sic_pkg.sv */
// Shared types and constants for the small ISA processor step block.
package sic_pkg;
  localparam logic [2:0] ITEM_EXEC = 3'd0;
  localparam logic [2:0] ITEM_LOAD = 3'd1;
  localparam logic [2:0] ITEM_WREG = 3'd2;
  localparam logic [2:0] ITEM_RREG = 3'd3;
  localparam logic [2:0] ITEM_SETPC = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DIVZ = 3'd1;
  localparam logic [2:0] ST_UNK = 3'd2;
  localparam logic [2:0] ST_HALT = 3'd3;
  localparam logic [2:0] ST_BUSY = 3'd4;

  localparam logic [5:0] OP_MOV = 6'h04;
  localparam logic [5:0] OP_ADD = 6'h05;
  localparam logic [5:0] OP_SUB = 6'h06;
  localparam logic [5:0] OP_MUL = 6'h07;
  localparam logic [5:0] OP_DIV = 6'h08;
  localparam logic [5:0] OP_AND = 6'h09;
  localparam logic [5:0] OP_OR = 6'h0A;
  localparam logic [5:0] OP_SLT = 6'h10;
  localparam logic [5:0] OP_ST = 6'h02;
  localparam logic [5:0] OP_LW = 6'h03;
  localparam logic [5:0] OP_MOVI = 6'h0B;
  localparam logic [5:0] OP_ADDI = 6'h0C;
  localparam logic [5:0] OP_MULI = 6'h0D;
  localparam logic [5:0] OP_DIVI = 6'h0E;
  localparam logic [5:0] OP_LDI = 6'h0F;
  localparam logic [5:0] OP_SLTI = 6'h11;
  localparam logic [5:0] OP_BEQ = 6'h15;
  localparam logic [5:0] OP_BNE = 6'h16;
  localparam logic [5:0] OP_BZ = 6'h17;
  localparam logic [5:0] OP_BNZ = 6'h18;
  localparam logic [5:0] OP_BPL = 6'h19;
  localparam logic [5:0] OP_BMI = 6'h1A;
  localparam logic [5:0] OP_HLT = 6'h12;
  localparam logic [5:0] OP_JMP = 6'h14;
  localparam logic [5:0] OP_RD = 6'h00;
  localparam logic [5:0] OP_WR = 6'h01;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_WB, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
    logic div_start;
    logic div_step;
    logic wb;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;
endpackage

/* design/sic_ctrl.sv */
// Controller state machine for the small ISA processor step block.
module sic_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sic_pkg::sts_t sts,
  output sic_pkg::cmd_t cmd
);
  sic_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sic_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      sic_pkg::S_IDLE: if (in_valid) state_next = sic_pkg::S_READ;
      sic_pkg::S_READ: state_next = sic_pkg::S_EXEC;
      sic_pkg::S_EXEC: state_next = sts.need_div ? sic_pkg::S_DIV : sic_pkg::S_WB;
      sic_pkg::S_DIV: if (sts.div_done) state_next = sic_pkg::S_WB;
      sic_pkg::S_WB: state_next = sic_pkg::S_OUT;
      sic_pkg::S_OUT: if (!out_stall) state_next = sic_pkg::S_IDLE;
      default: state_next = sic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      sic_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      sic_pkg::S_READ: cmd.read = 1'b1;
      sic_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.div_start = sts.need_div;
      end
      sic_pkg::S_DIV: cmd.div_step = 1'b1;
      sic_pkg::S_WB: begin
        cmd.wb = 1'b1;
        cmd.out_load = 1'b1;
      end
      sic_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

/* design/sic_datapath.sv */
// Register file, ALU, serial divider and architectural state.
module sic_datapath #(
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  sic_pkg::cmd_t cmd,
  output sic_pkg::sts_t sts,
  input  logic [15:0] base_address,
  input  logic debug_mode,
  input  logic [2:0] opcode,
  input  logic [31:0] instr_word,
  input  logic signed [31:0] load_data,
  input  logic [3:0] reg_index,
  input  logic signed [31:0] reg_value,
  output logic [2:0] status,
  output logic [15:0] fetch_addr,
  output logic mem_read,
  output logic mem_write,
  output logic [15:0] mem_addr,
  output logic signed [31:0] mem_wdata,
  output logic signed [31:0] reg_data,
  output logic halted,
  output logic [15:0] pc_value
);
  logic [31:0] regs [16];
  logic [15:0] rvalid;
  logic [ADDR_BITS-1:0] pc, pc_n;
  logic halt_flag, load_pending;
  logic [3:0] load_target;
  logic [2:0] i_opc;
  logic [31:0] i_w, i_ld, i_val;
  logic [3:0] i_idx;
  logic [31:0] a, b, c;
  logic [1:0] fmt;
  logic [5:0] op;
  logic [3:0] r1, r2, r3;
  logic [15:0] imm;
  // execute results
  logic        we;
  logic [3:0]  wa;
  logic [31:0] wd, wd_n;
  logic [2:0]  st, st_n;
  logic        rd, rd_n, wr, wr_n, we_n, hset_n, lp_n;
  logic [3:0]  wa_n;
  logic [ADDR_BITS-1:0] ma, ma_n;
  logic [31:0] wdat, wdat_n, rdat, rdat_n;
  logic        hset, lp_set;
  logic        ndiv;
  logic [31:0] dn, dd, ma_a, ma_b;
  // divider
  logic [31:0] quo, rem, dvs;
  logic [5:0]  dcnt;
  logic        dneg;

  function automatic logic [31:0] rdreg(input logic [15:0] v, input logic [31:0] x,
                                        input logic [3:0] i);
    logic [31:0] r;
    r = (i == 4'd1) ? 32'd0 : {28'd0, i};
    return v[i] ? x : r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] daddr(input logic [15:0] im, input logic [31:0] rv,
                                                 input logic [15:0] base);
    logic [31:0] w;
    logic [31:0] m;
    m = rv[31] ? (32'd0 - rv) : rv;
    w = rv[31] ? (32'd0 - (m >> 2)) : (m >> 2);
    if (im != 16'd0) w = {18'd0, im[15:2]};
    return ADDR_BITS'(w + {16'd0, base});
  endfunction

  assign fmt = i_w[31:30];
  assign op = i_w[29:24];
  assign r1 = i_w[23:20];
  assign r2 = i_w[19:16];
  assign r3 = i_w[15:12];
  assign imm = i_w[15:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      i_opc <= opcode; i_w <= instr_word; i_ld <= load_data;
      i_idx <= reg_index; i_val <= reg_value;
    end
    if (cmd.read) begin
      a <= rdreg(rvalid, regs[i_w[23:20]], i_w[23:20]);
      b <= rdreg(rvalid, regs[i_w[19:16]], i_w[19:16]);
      c <= rdreg(rvalid, regs[i_idx], i_idx);
    end
  end

  // divide operands: format 0 DIV uses a/b, DIVI uses b/imm
  always_comb begin
    dn = (fmt == 2'd0) ? a : b;
    dd = (fmt == 2'd0) ? b : {16'd0, imm};
    ma_a = dn[31] ? 32'd0 - dn : dn;
    ma_b = dd[31] ? 32'd0 - dd : dd;
  end

  always_comb begin
    ndiv = 1'b0;
    if (i_opc == sic_pkg::ITEM_EXEC && !halt_flag && !load_pending) begin
      if (fmt == 2'd0 && op == sic_pkg::OP_DIV && b != 32'd0) ndiv = 1'b1;
      if (fmt == 2'd1 && op == sic_pkg::OP_DIVI && imm != 16'd0) ndiv = 1'b1;
    end
  end
  assign sts.need_div = ndiv;
  assign sts.div_done = (dcnt == 6'd0);

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= ma_a; rem <= '0; dvs <= ma_b; dcnt <= 6'd32;
      dneg <= dn[31] ^ dd[31];
    end else if (cmd.div_step && dcnt != 6'd0) begin
      if ({rem[30:0], quo[31]} >= dvs) begin
        rem <= {rem[30:0], quo[31]} - dvs;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
  end

  always_comb begin
    logic take;
    logic [ADDR_BITS-1:0] tgt;
    take = 1'b0;
    tgt = ADDR_BITS'(imm[15:2]);
    pc_n = pc; st_n = sic_pkg::ST_OK; we_n = 1'b0; wa_n = r3; wd_n = '0;
    rd_n = 1'b0; wr_n = 1'b0; ma_n = '0; wdat_n = '0; rdat_n = '0;
    hset_n = 1'b0; lp_n = 1'b0;
    case (i_opc)
      sic_pkg::ITEM_EXEC: begin
        if (halt_flag) st_n = sic_pkg::ST_HALT;
        else if (load_pending) st_n = sic_pkg::ST_BUSY;
        else begin
          pc_n = pc + 1'b1;
          case (fmt)
            2'd0: begin
              we_n = 1'b1;
              case (op)
                sic_pkg::OP_MOV: begin wa_n = r1; wd_n = b; end
                sic_pkg::OP_ADD: wd_n = a + b;
                sic_pkg::OP_SUB: wd_n = a - b;
                sic_pkg::OP_MUL: wd_n = a * b;
                sic_pkg::OP_DIV: if (b == 32'd0) begin
                  we_n = 1'b0; st_n = sic_pkg::ST_DIVZ;
                end
                sic_pkg::OP_AND: wd_n = a & b;
                sic_pkg::OP_OR: wd_n = a | b;
                sic_pkg::OP_SLT: wd_n = {31'd0, $signed(a) < $signed(b)};
                default: begin we_n = 1'b0; st_n = sic_pkg::ST_UNK; end
              endcase
            end
            2'd1: begin
              wa_n = r2;
              case (op)
                sic_pkg::OP_ST: begin
                  wr_n = 1'b1; ma_n = daddr(imm, b, base_address); wdat_n = a;
                end
                sic_pkg::OP_LW: begin
                  rd_n = 1'b1; ma_n = daddr(imm, a, base_address); lp_n = 1'b1;
                end
                sic_pkg::OP_MOVI, sic_pkg::OP_LDI: begin we_n = 1'b1; wd_n = {16'd0, imm}; end
                sic_pkg::OP_ADDI: begin we_n = 1'b1; wd_n = b + {16'd0, imm}; end
                sic_pkg::OP_MULI: begin we_n = 1'b1; wd_n = b * {16'd0, imm}; end
                sic_pkg::OP_DIVI: if (imm == 16'd0) st_n = sic_pkg::ST_DIVZ;
                  else we_n = 1'b1;
                sic_pkg::OP_SLTI: begin
                  we_n = 1'b1; wd_n = {31'd0, $signed(a) < $signed({16'd0, imm})};
                end
                sic_pkg::OP_BEQ: take = (a == b);
                sic_pkg::OP_BNE: take = (a != b);
                sic_pkg::OP_BZ: take = (a == 32'd0);
                sic_pkg::OP_BNZ: take = (a != 32'd0);
                sic_pkg::OP_BPL: take = (a != 32'd0) && !a[31];
                sic_pkg::OP_BMI: take = a[31];
                default: st_n = sic_pkg::ST_UNK;
              endcase
              if (take) pc_n = tgt;
            end
            2'd2: begin
              if (op == sic_pkg::OP_HLT) hset_n = 1'b1;
              else if (op == sic_pkg::OP_JMP) pc_n = ADDR_BITS'(i_w[23:2]);
              else st_n = sic_pkg::ST_UNK;
            end
            default: begin
              wa_n = r1;
              if (op == sic_pkg::OP_RD) begin
                if (!debug_mode) begin
                  rd_n = 1'b1; ma_n = daddr(imm, b, base_address); lp_n = 1'b1;
                end
              end else if (op == sic_pkg::OP_WR) begin
                if (!debug_mode) begin
                  wr_n = 1'b1; ma_n = daddr(imm, b, base_address); wdat_n = a;
                end
              end else st_n = sic_pkg::ST_UNK;
            end
          endcase
        end
      end
      sic_pkg::ITEM_LOAD: if (!load_pending) st_n = sic_pkg::ST_BUSY;
        else begin we_n = 1'b1; wa_n = load_target; wd_n = i_ld; end
      sic_pkg::ITEM_WREG: begin we_n = 1'b1; wa_n = i_idx; wd_n = i_val; end
      sic_pkg::ITEM_RREG: rdat_n = c;
      sic_pkg::ITEM_SETPC: pc_n = i_val[ADDR_BITS-1:0];
      default: st_n = sic_pkg::ST_BUSY;
    endcase
  end

  logic [ADDR_BITS-1:0] pc_hold;
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      we <= we_n; wa <= wa_n; wd <= wd_n; st <= st_n; rd <= rd_n; wr <= wr_n;
      ma <= ma_n; wdat <= wdat_n; rdat <= rdat_n; hset <= hset_n; lp_set <= lp_n;
      pc_hold <= pc_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0; pc <= '0; halt_flag <= 1'b0; load_pending <= 1'b0;
      load_target <= '0;
    end else if (cmd.wb) begin
      pc <= pc_hold;
      if (hset) halt_flag <= 1'b1;
      if (lp_set) begin
        load_pending <= 1'b1; load_target <= wa;
      end else if (i_opc == sic_pkg::ITEM_LOAD) load_pending <= 1'b0;
      if (we) rvalid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb && we) regs[wa] <= ndiv ? (dneg ? 32'd0 - quo : quo) : wd;
  end

  // output register; loaded in writeback using the new state values
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= st; mem_read <= rd; mem_write <= wr; mem_addr <= 16'(ma);
      mem_wdata <= wdat; reg_data <= rdat;
      halted <= halt_flag | hset;
      pc_value <= 16'(pc_hold);
      fetch_addr <= 16'(ADDR_BITS'({8'd0, base_address} + 24'(pc_hold)));
    end
  end
endmodule

/* design/small_isa_cpu_step.sv */
// Top level of the small ISA processor step block.
// Usage:
//  - The input channel (in_valid/in_stall) carries one beat per item: an
//    opcode plus instruction, load data, register index and register value.
//  - The output channel (out_valid/out_stall) returns exactly one result beat
//    per input beat: status, fetch address, memory request, register read,
//    halt flag and program counter.
//  - Configuration (cfg_we/cfg_index/cfg_data) writes base_address (index 0)
//    and debug_mode (index 1); write only while idle.
//  - After acceptance an item passes through the register read, execute,
//    writeback and present states before its result beat; the next item can
//    be accepted in the cycle after the result is taken. A DIV or DIVI with
//    a nonzero divisor adds the divide state (restoring, one bit per cycle).
//  - One item is in flight at a time; in_stall stays high until the result
//    beat has been taken.
//  - While the receiver stalls, the result holds in the output register and
//    no new item is accepted.
//  - Reset clears the controller, program counter, halt and load marks, and
//    the register valid bits, so registers read back their reset values
//    (index, register one zero) until written. No clearing pass is needed.
module small_isa_cpu_step #(
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] opcode,
  input  logic [31:0] instr_word,
  input  logic signed [31:0] load_data,
  input  logic [3:0] reg_index,
  input  logic signed [31:0] reg_value,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [15:0] fetch_addr,
  output logic mem_read,
  output logic mem_write,
  output logic [15:0] mem_addr,
  output logic signed [31:0] mem_wdata,
  output logic signed [31:0] reg_data,
  output logic halted,
  output logic [15:0] pc_value,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
  `include "small_isa_cpu_step_assert.svh"

  sic_pkg::cmd_t cmd;
  sic_pkg::sts_t sts;
  logic [15:0] base_address;
  logic debug_mode;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      debug_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) base_address <= cfg_data;
      else debug_mode <= cfg_data[0];
    end
  end

  sic_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  sic_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .base_address, .debug_mode,
    .opcode, .instr_word, .load_data, .reg_index, .reg_value,
    .status, .fetch_addr, .mem_read, .mem_write, .mem_addr, .mem_wdata,
    .reg_data, .halted, .pc_value
  );

  // no new beat is taken while a result is on offer
  `SIC_ASSERT_IMPL(a_one_in_flight, out_valid, in_stall)
  // a stalled result holds
  `SIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // halt flag never clears outside reset
  `SIC_ASSERT_NEXT(a_halt_sticky, out_valid && halted, halted)
endmodule

/* verif/tb_small_isa_cpu_step.sv */
// Testbench for small_isa_cpu_step: predicts each result beat and checks it in order.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  status;
  logic [15:0] fetch_addr;
  logic        mem_read;
  logic        mem_write;
  logic [15:0] mem_addr;
  logic [31:0] mem_wdata;
  logic [31:0] reg_data;
  logic        halted;
  logic [15:0] pc_value;
} result_t;

class cpu_scoreboard;
  logic [31:0] regs [16];
  logic [15:0] pc;
  bit          halt_flag;
  bit          load_busy;
  logic [3:0]  load_dest;
  logic [15:0] base;
  bit          debug;
  result_t     pending_results[$];
  int          errors;

  function new();
    for (int i = 0; i < 16; i++) regs[i] = i;
    regs[1] = 0;
    pc = 0; halt_flag = 0; load_busy = 0; load_dest = 0;
    base = 0; debug = 0; errors = 0;
  endfunction

  function void set_reg(bit idx, logic [15:0] val);
    if (idx == 1'b0) base = val;
    else debug = val[0];
  endfunction

  static function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function logic [15:0] data_word(logic [15:0] imm, logic [31:0] rv);
    logic [31:0] w;
    w = (imm == 0) ? sdiv(rv, 32'd4) : {16'd0, imm} >> 2;
    return w[15:0] + base;
  endfunction

  // Execute one instruction word; return status code.
  function logic [2:0] run_instr(logic [31:0] w, ref result_t r);
    logic [1:0]  fmt;
    logic [5:0]  op;
    logic [3:0]  a, b, d;
    logic [15:0] imm;
    bit          take;
    fmt = w[31:30]; op = w[29:24];
    a = w[23:20]; b = w[19:16]; d = w[15:12]; imm = w[15:0];
    take = 0;
    pc = pc + 16'd1;
    case (fmt)
      2'd0: begin
        case (op)
          sic_pkg::OP_MOV: regs[a] = regs[b];
          sic_pkg::OP_ADD: regs[d] = regs[a] + regs[b];
          sic_pkg::OP_SUB: regs[d] = regs[a] - regs[b];
          sic_pkg::OP_MUL: regs[d] = regs[a] * regs[b];
          sic_pkg::OP_DIV: begin
            if (regs[b] == 0) return sic_pkg::ST_DIVZ;
            regs[d] = sdiv(regs[a], regs[b]);
          end
          sic_pkg::OP_AND: regs[d] = regs[a] & regs[b];
          sic_pkg::OP_SLT: regs[d] = ($signed(regs[a]) < $signed(regs[b])) ? 1 : 0;
          sic_pkg::OP_OR:  regs[d] = regs[a] | regs[b];
          default: return sic_pkg::ST_UNK;
        endcase
      end
      2'd1: begin
        case (op)
          sic_pkg::OP_ST: begin
            r.mem_write = 1; r.mem_addr = data_word(imm, regs[b]); r.mem_wdata = regs[a];
          end
          sic_pkg::OP_LW: begin
            r.mem_read = 1; r.mem_addr = data_word(imm, regs[a]);
            load_busy = 1; load_dest = b;
          end
          sic_pkg::OP_MOVI, sic_pkg::OP_LDI: regs[b] = {16'd0, imm};
          sic_pkg::OP_ADDI: regs[b] = regs[b] + {16'd0, imm};
          sic_pkg::OP_MULI: regs[b] = regs[b] * {16'd0, imm};
          sic_pkg::OP_DIVI: begin
            if (imm == 0) return sic_pkg::ST_DIVZ;
            regs[b] = sdiv(regs[b], {16'd0, imm});
          end
          sic_pkg::OP_SLTI: regs[b] = ($signed(regs[a]) < $signed({16'd0, imm})) ? 1 : 0;
          sic_pkg::OP_BEQ: take = regs[a] == regs[b];
          sic_pkg::OP_BNE: take = regs[a] != regs[b];
          sic_pkg::OP_BZ:  take = regs[a] == 0;
          sic_pkg::OP_BNZ: take = regs[a] != 0;
          sic_pkg::OP_BPL: take = regs[a] != 0 && !regs[a][31];
          sic_pkg::OP_BMI: take = regs[a][31];
          default: return sic_pkg::ST_UNK;
        endcase
        if (take) pc = imm >> 2;
      end
      2'd2: begin
        if (op == sic_pkg::OP_HLT) halt_flag = 1;
        else if (op == sic_pkg::OP_JMP) pc = w[17:2];
        else return sic_pkg::ST_UNK;
      end
      default: begin
        if (op == sic_pkg::OP_RD) begin
          if (!debug) begin
            r.mem_read = 1; r.mem_addr = data_word(imm, regs[b]);
            load_busy = 1; load_dest = a;
          end
        end else if (op == sic_pkg::OP_WR) begin
          if (!debug) begin
            r.mem_write = 1; r.mem_addr = data_word(imm, regs[b]); r.mem_wdata = regs[a];
          end
        end else return sic_pkg::ST_UNK;
      end
    endcase
    return sic_pkg::ST_OK;
  endfunction

  // Note an accepted input beat and queue its expected result.
  function void note_input(logic [2:0] opc, logic [31:0] w, logic [31:0] ld,
                           logic [3:0] idx, logic [31:0] val);
    result_t r;
    r = '{default: '0};
    case (opc)
      sic_pkg::ITEM_EXEC: begin
        if (halt_flag) r.status = sic_pkg::ST_HALT;
        else if (load_busy) r.status = sic_pkg::ST_BUSY;
        else r.status = run_instr(w, r);
      end
      sic_pkg::ITEM_LOAD: begin
        if (load_busy) begin
          regs[load_dest] = ld; load_busy = 0;
        end else r.status = sic_pkg::ST_BUSY;
      end
      sic_pkg::ITEM_WREG:  regs[idx] = val;
      sic_pkg::ITEM_RREG:  r.reg_data = regs[idx];
      sic_pkg::ITEM_SETPC: pc = val[15:0];
      default: r.status = sic_pkg::ST_BUSY;
    endcase
    r.fetch_addr = base + pc;
    r.halted = halt_flag;
    r.pc_value = pc;
    pending_results.push_back(r);
  endfunction

  function void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // Check one accepted result beat against the oldest expectation.
  function void check_result(result_t act);
    result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with none expected, status %h", $time, act.status);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    cmp("status", e.status, act.status);
    cmp("fetch_addr", e.fetch_addr, act.fetch_addr);
    cmp("mem_read", e.mem_read, act.mem_read);
    cmp("mem_write", e.mem_write, act.mem_write);
    cmp("mem_addr", e.mem_addr, act.mem_addr);
    cmp("mem_wdata", e.mem_wdata, act.mem_wdata);
    cmp("reg_data", e.reg_data, act.reg_data);
    cmp("halted", e.halted, act.halted);
    cmp("pc_value", e.pc_value, act.pc_value);
  endfunction
endclass

module tb_small_isa_cpu_step;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [31:0] instr_word = '0;
  logic signed [31:0] load_data = '0;
  logic [3:0] reg_index = '0;
  logic signed [31:0] reg_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [15:0] fetch_addr;
  logic mem_read, mem_write;
  logic [15:0] mem_addr;
  logic signed [31:0] mem_wdata, reg_data;
  logic halted;
  logic [15:0] pc_value;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_data = '0;

  cpu_scoreboard sb;

  small_isa_cpu_step dut (.*);

  always #10 clk = ~clk;

  // Receiver: random stall per beat, check every accepted result.
  initial begin
    int gap;
    result_t act;
    wait (sb != null);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        act.status = status; act.fetch_addr = fetch_addr;
        act.mem_read = mem_read; act.mem_write = mem_write;
        act.mem_addr = mem_addr; act.mem_wdata = mem_wdata;
        act.reg_data = reg_data; act.halted = halted; act.pc_value = pc_value;
        sb.check_result(act);
        gap = $urandom_range(0, 3);
        // Bursts without stalls now and then.
        if ($urandom_range(0, 7) == 0) gap = 0;
        if (gap > 0) begin
          out_stall <= 1;
          repeat (gap) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // Send one beat; hold it until accepted, then drop valid for a random gap (possibly none).
  task automatic send_beat(logic [2:0] opc, logic [31:0] w, logic [31:0] ld,
                           logic [3:0] idx, logic [31:0] val);
    int gap;
    opcode <= opc; instr_word <= w; load_data <= ld;
    reg_index <= idx; reg_value <= val; in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(opc, w, ld, idx, val);
    gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until nothing is expected, then let the core settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(bit idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [31:0] enc(logic [1:0] fmt, logic [5:0] op, logic [23:0] rest);
    return {fmt, op, rest};
  endfunction

  task automatic exec(logic [31:0] w);
    send_beat(sic_pkg::ITEM_EXEC, w, $urandom, 4'($urandom), $urandom);
  endtask

  // Pick a mostly valid instruction with random fields.
  function automatic logic [31:0] rand_instr();
    logic [5:0] ops0 [8] = '{sic_pkg::OP_MOV, sic_pkg::OP_ADD, sic_pkg::OP_SUB,
                             sic_pkg::OP_MUL, sic_pkg::OP_DIV, sic_pkg::OP_AND,
                             sic_pkg::OP_OR, sic_pkg::OP_SLT};
    logic [5:0] ops1 [17] = '{sic_pkg::OP_ST, sic_pkg::OP_LW, sic_pkg::OP_MOVI,
                              sic_pkg::OP_ADDI, sic_pkg::OP_MULI, sic_pkg::OP_DIVI,
                              sic_pkg::OP_LDI, sic_pkg::OP_SLTI, sic_pkg::OP_BEQ,
                              sic_pkg::OP_BNE, sic_pkg::OP_BZ, sic_pkg::OP_BNZ,
                              sic_pkg::OP_BPL, sic_pkg::OP_BMI, sic_pkg::OP_ST,
                              sic_pkg::OP_LW, sic_pkg::OP_DIVI};
    logic [23:0] rest;
    int k;
    rest = 24'($urandom);
    if ($urandom_range(0, 3) == 0) rest[15:0] = 16'd0;
    else if ($urandom_range(0, 3) == 0) rest[15:0] = 16'($urandom_range(0, 3));
    k = $urandom_range(0, 99);
    if (k < 30) return enc(2'd0, ops0[$urandom_range(0, 7)], rest);
    if (k < 75) return enc(2'd1, ops1[$urandom_range(0, 16)], rest);
    if (k < 80) return enc(2'd2, sic_pkg::OP_JMP, rest);
    if (k < 90) return enc(2'd3, $urandom_range(0, 1) ? sic_pkg::OP_RD : sic_pkg::OP_WR,
                           rest);
    if (k < 91) return enc(2'd2, sic_pkg::OP_HLT, rest);
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      // Answer a pending load most of the time to keep the core moving.
      if (sb.load_busy && $urandom_range(0, 4) != 0) begin
        send_beat(sic_pkg::ITEM_LOAD, $urandom, $urandom, 4'($urandom), $urandom);
        continue;
      end
      k = $urandom_range(0, 99);
      if (k < 70) exec(rand_instr());
      else if (k < 78) send_beat(sic_pkg::ITEM_WREG, $urandom, $urandom, 4'($urandom),
                                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
      else if (k < 86) send_beat(sic_pkg::ITEM_RREG, $urandom, $urandom, 4'($urandom),
                                 $urandom);
      else if (k < 92) send_beat(sic_pkg::ITEM_SETPC, $urandom, $urandom, 4'($urandom),
                                 $urandom);
      else if (k < 96) send_beat(sic_pkg::ITEM_LOAD, $urandom, $urandom, 4'($urandom),
                                 $urandom);
      else send_beat(3'($urandom_range(5, 7)), $urandom, $urandom, 4'($urandom), $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_cfg(1'b0, 16'h0000);
    write_cfg(1'b1, 16'h0000);

    // Directed: extremes, division corners, loads, jumps and an unknown item.
    send_beat(sic_pkg::ITEM_RREG, 0, 0, 4'd1, 0);
    send_beat(sic_pkg::ITEM_WREG, 0, 0, 4'd2, 32'h8000_0000);
    send_beat(sic_pkg::ITEM_WREG, 0, 0, 4'd3, 32'hFFFF_FFFF);
    exec(enc(2'd0, sic_pkg::OP_DIV, {4'd2, 4'd3, 4'd4, 12'd0}));    // min / -1 wraps
    exec(enc(2'd0, sic_pkg::OP_DIV, {4'd2, 4'd1, 4'd4, 12'd0}));    // divide by zero
    exec(enc(2'd1, sic_pkg::OP_DIVI, {4'd0, 4'd5, 16'd0}));         // immediate divide by zero
    exec(enc(2'd1, sic_pkg::OP_DIVI, {4'd0, 4'd2, 16'hFFFF}));
    exec(enc(2'd0, sic_pkg::OP_ADD, {4'd3, 4'd3, 4'd6, 12'd0}));    // wraparound
    exec(enc(2'd0, sic_pkg::OP_SLT, {4'd2, 4'd3, 4'd7, 12'd0}));
    exec(enc(2'd0, 6'h3F, 24'hFFFFFF));                             // unknown opcode
    exec(enc(2'd1, sic_pkg::OP_LW, {4'd2, 4'd8, 16'd0}));           // register-indirect load
    exec(enc(2'd0, sic_pkg::OP_ADD, 24'd0));                        // busy while load pending
    send_beat(sic_pkg::ITEM_LOAD, 0, 32'h7FFF_FFFF, 0, 0);
    send_beat(sic_pkg::ITEM_LOAD, 0, 32'h8000_0000, 0, 0);          // no load pending
    exec(enc(2'd1, sic_pkg::OP_ST, {4'd3, 4'd2, 16'hFFFF}));
    exec(enc(2'd3, sic_pkg::OP_RD, {4'd9, 4'd3, 16'd0}));
    send_beat(sic_pkg::ITEM_LOAD, 0, 32'h1234_5678, 0, 0);
    exec(enc(2'd3, sic_pkg::OP_WR, {4'd9, 4'd2, 16'd0}));
    send_beat(sic_pkg::ITEM_SETPC, 0, 0, 0, 32'hFFFF_FFFF);
    exec(enc(2'd2, sic_pkg::OP_JMP, 24'hFFFFFF));
    send_beat(3'd7, 32'hFFFF_FFFF, 0, 4'd15, 0);
    drain();

    // Debug mode, maximum base.
    write_cfg(1'b1, 16'h0001);
    write_cfg(1'b0, 16'hFFFF);
    exec(enc(2'd3, sic_pkg::OP_RD, {4'd1, 4'd2, 16'd8}));
    exec(enc(2'd3, sic_pkg::OP_WR, {4'd1, 4'd2, 16'd8}));
    random_phase(120);
    drain();

    write_cfg(1'b1, 16'h0000);
    write_cfg(1'b0, 16'($urandom));
    random_phase(200);
    drain();   // sender pauses until every result is back

    write_cfg(1'b0, 16'h8000);
    random_phase(200);
    exec(enc(2'd2, sic_pkg::OP_HLT, 24'd0));
    exec(enc(2'd0, sic_pkg::OP_ADD, 24'd0));                        // execute while halted
    send_beat(sic_pkg::ITEM_WREG, 0, 0, 4'd5, 32'h5A5A_5A5A);
    random_phase(60);
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("small_isa_cpu_step verification clean");
    else
      $display("small_isa_cpu_step verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("small_isa_cpu_step verification failed");
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/sic_pkg.sv
design/sic_ctrl.sv
design/sic_datapath.sv
design/small_isa_cpu_step.sv
verif/tb_small_isa_cpu_step.sv
